// File: rtl/core/rbia_pkg.sv
`timescale 1ns / 1ps

package rbia_pkg;

    localparam int MAP_WIDTH = 64;
    localparam int ID_WIDTH  = 6;

    typedef logic [MAP_WIDTH-1:0] map_t;
    typedef logic [ID_WIDTH-1:0]  id_t;

    typedef enum logic
    {
        ACT_ACQUIRE = 1'b0,
        ACT_RELEASE = 1'b1
    } action_t;

    // bit k of the index is clear when the one-hot bit falls inside mask k
    localparam map_t IDX_MASK [ID_WIDTH] = '{
        64'h5555555555555555,
        64'h3333333333333333,
        64'h0F0F0F0F0F0F0F0F,
        64'h00FF00FF00FF00FF,
        64'h0000FFFF0000FFFF,
        64'h00000000FFFFFFFF
    };

    typedef struct packed
    {
        logic found;
        id_t  index;
        map_t claim;
    } pick_t;

endpackage

// File: rtl/core/rbia_pick.sv
`timescale 1ns / 1ps

module rbia_pick
(
    input  rbia_pkg::map_t  used,
    output rbia_pkg::pick_t pick
);

    rbia_pkg::map_t isolated;
    rbia_pkg::id_t  index;

    // lowest zero of the used map, as a one-hot word
    assign isolated = ~used & (used + rbia_pkg::MAP_WIDTH'(1));

    always_comb
    begin
        for (int k = 0; k < rbia_pkg::ID_WIDTH; k++)
        begin
            index[k] = ~|(isolated & rbia_pkg::IDX_MASK[k]);
        end
    end

    assign pick.found = |isolated;
    assign pick.index = pick.found ? index : '0;
    assign pick.claim = isolated;

endmodule

// File: rtl/core/rotating_bitmap_id_allocator_core.sv
`timescale 1ns / 1ps

// Identifier allocator for ids 0 to SLOT_COUNT-1 with a rotating search start.
// Input stream s_axis: tuser carries the action (0 acquire, 1 release),
// tdata carries the id to release. Output stream m_axis: tuser is the grant
// flag, tdata carries the granted id and the busy map after the transaction.
// An acquire takes the lowest free id at or above the start counter, which
// advances by one on every acquire; with nothing free there it fails.
// A release clears the named id. Every input gives exactly one output.
// An input transaction passes through one input register, then the search over
// the 64-bit map into the result register. Throughput is one transaction per
// clock while the receiver keeps m_axis_tready high; the map and counter update
// in the cycle that moves an item from the input register to the result.
// Reset clears the busy map, the start counter and both valid flags.
// When the receiver stalls, the result holds, the input register fills and
// s_axis_tready drops until the result is taken.
module rotating_bitmap_id_allocator_core
#(
    parameter int SLOT_COUNT = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [5:0] release_id, [7:6] zero
    input  logic        s_axis_tuser,   // [0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [5:0] given_id, [69:6] busy_map, [71:70] zero
    output logic        m_axis_tuser    // [0] granted
);

    localparam rbia_pkg::map_t VALID_MASK = (SLOT_COUNT >= rbia_pkg::MAP_WIDTH) ?
        '1 : ((rbia_pkg::MAP_WIDTH'(1) << SLOT_COUNT) - rbia_pkg::MAP_WIDTH'(1));

    logic               in_valid_reg;
    rbia_pkg::action_t  in_action_reg;
    rbia_pkg::id_t      in_id_reg;
    logic               out_valid_reg;
    logic               out_granted_reg;
    rbia_pkg::id_t      out_id_reg;
    rbia_pkg::map_t     busy_reg;
    rbia_pkg::map_t     busy_next;
    rbia_pkg::id_t      start_reg;
    rbia_pkg::id_t      start_next;
    rbia_pkg::map_t     below;
    rbia_pkg::map_t     used;
    rbia_pkg::pick_t    pick;
    logic               granted_next;
    rbia_pkg::id_t      id_next;
    logic               advance;
    logic               take_in;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign take_in       = s_axis_tvalid && s_axis_tready;

    assign below = (rbia_pkg::MAP_WIDTH'(1) << start_reg) - rbia_pkg::MAP_WIDTH'(1);
    assign used  = busy_reg | below | ~VALID_MASK;

    rbia_pick u_pick
    (
        .used (used),
        .pick (pick)
    );

    always_comb
    begin
        busy_next    = busy_reg;
        start_next   = start_reg;
        granted_next = 1'b0;
        id_next      = '0;
        case (in_action_reg)
            rbia_pkg::ACT_ACQUIRE:
            begin
                start_next   = start_reg + rbia_pkg::ID_WIDTH'(1);
                busy_next    = busy_reg | pick.claim;
                granted_next = pick.found;
                id_next      = pick.index;
            end
            rbia_pkg::ACT_RELEASE:
            begin
                busy_next = busy_reg & ~(rbia_pkg::MAP_WIDTH'(1) << in_id_reg);
            end
            default:
            begin
                busy_next = busy_reg;
            end
        endcase
        busy_next = busy_next & VALID_MASK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            busy_reg      <= '0;
            start_reg     <= '0;
        end
        else
        begin
            if (take_in)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                busy_reg      <= busy_next;
                start_reg     <= start_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_action_reg <= rbia_pkg::action_t'(s_axis_tuser);
            in_id_reg     <= s_axis_tdata[rbia_pkg::ID_WIDTH-1:0];
        end
        if (advance)
        begin
            out_granted_reg <= granted_next;
            out_id_reg      <= id_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_granted_reg;
    assign m_axis_tdata  = {2'b00, busy_reg, out_id_reg};

endmodule

// File: rtl/core/rbia_checker.sv
`timescale 1ns / 1ps

module rbia_checker
#(
    parameter int SLOT_COUNT = 64
)
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    localparam rbia_pkg::map_t VALID_MASK = (SLOT_COUNT >= rbia_pkg::MAP_WIDTH) ?
        '1 : ((rbia_pkg::MAP_WIDTH'(1) << SLOT_COUNT) - rbia_pkg::MAP_WIDTH'(1));

    rbia_pkg::map_t busy_map;
    rbia_pkg::id_t  given_id;

    assign busy_map = m_axis_tdata[69:6];
    assign given_id = m_axis_tdata[5:0];

    // a stalled input transaction holds until it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata)
            && $stable(s_axis_tuser))
    else $error("stalled input changed");

    // a stalled result holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
    else $error("stalled result changed");

    // a failed or release transaction reports id zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> given_id == '0)
    else $error("nonzero id without grant");

    // the granted id is marked busy in the reported map
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> busy_map[given_id])
    else $error("granted id not busy");

    // ids outside the slot range never appear busy
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (busy_map & ~VALID_MASK) == '0)
    else $error("busy bit beyond slot count");

endmodule

bind rotating_bitmap_id_allocator_core rbia_checker #(.SLOT_COUNT(SLOT_COUNT)) u_rbia_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// File: bench/tb_rotating_bitmap_id_allocator_core.sv
`timescale 1ns / 1ps

module tb_rotating_bitmap_id_allocator_core;

    localparam int   SLOT_COUNT     = 64;
    localparam rbia_pkg::map_t SLOT_VALID = (SLOT_COUNT >= rbia_pkg::MAP_WIDTH) ? '1
        : ((rbia_pkg::map_t'(1) << SLOT_COUNT) - rbia_pkg::map_t'(1));
    localparam int   RANDOM_ITEMS   = 1700;
    localparam int   WATCHDOG_LIMIT = 2000;
    localparam int   SETTLE_CYCLES  = 8;

    typedef struct packed
    {
        logic           granted;
        rbia_pkg::id_t  given;
        rbia_pkg::map_t busy;
    } grant_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;    // [5:0] release_id, [7:6] zero
    logic        s_axis_tuser;    // [0] action
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;    // [5:0] given_id, [69:6] busy_map, [71:70] zero
    logic        m_axis_tuser;    // [0] granted

    // shadow copy of the allocator state
    rbia_pkg::map_t alloc_busy;
    rbia_pkg::id_t  alloc_start;
    grant_t         expected_grants[$];

    int mismatch_count;
    int burst_left;
    int idle_cycles;
    int rx_mode;
    int rx_left;
    int rx_phase;

    rotating_bitmap_id_allocator_core #(.SLOT_COUNT(SLOT_COUNT)) u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void predict_grant(input rbia_pkg::action_t act,
                                          input rbia_pkg::id_t rid);
        grant_t         res;
        rbia_pkg::map_t taken;
        bit             found;
        res   = '0;
        found = 1'b0;
        if (act == rbia_pkg::ACT_ACQUIRE)
        begin
            // everything below the start position counts as taken
            taken = alloc_busy | ~SLOT_VALID;
            for (int k = 0; k < rbia_pkg::MAP_WIDTH; k++)
            begin
                if (!found && k >= int'(alloc_start) && !taken[k])
                begin
                    found       = 1'b1;
                    res.granted = 1'b1;
                    res.given   = rbia_pkg::id_t'(k);
                    alloc_busy[k] = 1'b1;
                end
            end
            alloc_start = alloc_start + rbia_pkg::id_t'(1);
        end
        else
        begin
            alloc_busy[rid] = 1'b0;
        end
        alloc_busy = alloc_busy & SLOT_VALID;
        res.busy   = alloc_busy;
        expected_grants = {expected_grants, res};
    endfunction

    task automatic send_item(input rbia_pkg::action_t act, input rbia_pkg::id_t rid);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250)
                                                     : $urandom_range(1, 30);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, rid};
        s_axis_tuser  <= act;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_grant(act, rid);
    endtask

    task automatic wait_all_results();
        burst_left = 0;
        if (expected_grants.size() != 0)
        begin
            s_axis_tvalid <= 1'b0;
            while (expected_grants.size() != 0)
                @(posedge clk);
        end
    endtask

    function automatic rbia_pkg::id_t pick_busy_id();
        rbia_pkg::id_t k;
        k = rbia_pkg::id_t'($urandom_range(0, rbia_pkg::MAP_WIDTH - 1));
        if (alloc_busy != '0)
        begin
            while (!alloc_busy[k])
                k = k + rbia_pkg::id_t'(1);
        end
        return k;
    endfunction

    task automatic test_directed_basics();
        send_item(rbia_pkg::ACT_ACQUIRE, 6'd0);
        send_item(rbia_pkg::ACT_ACQUIRE, 6'd63);
        send_item(rbia_pkg::ACT_ACQUIRE, 6'd0);
        send_item(rbia_pkg::ACT_RELEASE, 6'd1);
        // id 1 is free but lies below the start now
        send_item(rbia_pkg::ACT_ACQUIRE, 6'd0);
        send_item(rbia_pkg::ACT_RELEASE, 6'd63);
        send_item(rbia_pkg::ACT_RELEASE, 6'd0);
        send_item(rbia_pkg::ACT_RELEASE, 6'd0);
        send_item(rbia_pkg::ACT_ACQUIRE, 6'd42);
        send_item(rbia_pkg::ACT_RELEASE, 6'd42);
        send_item(rbia_pkg::ACT_RELEASE, 6'd21);
        send_item(rbia_pkg::ACT_ACQUIRE, 6'd21);
        send_item(rbia_pkg::ACT_RELEASE, 6'd5);
        send_item(rbia_pkg::ACT_ACQUIRE, 6'd63);
    endtask

    task automatic test_exhaustion();
        for (int i = 0; i < rbia_pkg::MAP_WIDTH; i++)
            send_item(rbia_pkg::ACT_RELEASE, rbia_pkg::id_t'(i));
        // fill the whole map across a counter wrap, then fail
        for (int i = 0; i < 70; i++)
            send_item(rbia_pkg::ACT_ACQUIRE, rbia_pkg::id_t'($urandom_range(0, 63)));
        // low id free, everything at or above the start still taken
        send_item(rbia_pkg::ACT_RELEASE, 6'd0);
        send_item(rbia_pkg::ACT_ACQUIRE, 6'd0);
        send_item(rbia_pkg::ACT_ACQUIRE, 6'd0);
        wait_all_results();
    endtask

    task automatic test_random_traffic();
        int            acquire_pct;
        rbia_pkg::id_t rid;
        acquire_pct = 50;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 100 == 0)
            begin
                case ($urandom_range(0, 3))
                    0: acquire_pct = 20;
                    1: acquire_pct = 50;
                    2: acquire_pct = 80;
                    default: acquire_pct = 95;
                endcase
            end
            if ($urandom_range(0, 299) == 0)
                wait_all_results();
            if ($urandom_range(1, 100) <= acquire_pct)
            begin
                send_item(rbia_pkg::ACT_ACQUIRE, rbia_pkg::id_t'($urandom_range(0, 63)));
            end
            else
            begin
                rid = ($urandom_range(0, 99) < 85) ? pick_busy_id()
                                                   : rbia_pkg::id_t'($urandom_range(0, 63));
                send_item(rbia_pkg::ACT_RELEASE, rid);
            end
        end
    endtask

    // result checker, receiver stall pattern and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_grants.size() == 0)
                begin
                    $display("%0t: unexpected result tuser=%b tdata=%h",
                             $time, m_axis_tuser, m_axis_tdata);
                    mismatch_count++;
                end
                else
                begin
                    grant_t exp_res;
                    exp_res = expected_grants.pop_front();
                    if (m_axis_tuser !== exp_res.granted)
                    begin
                        $display("%0t: granted expected %b actual %b",
                                 $time, exp_res.granted, m_axis_tuser);
                        mismatch_count++;
                    end
                    if (m_axis_tdata[5:0] !== exp_res.given)
                    begin
                        $display("%0t: given_id expected %0d actual %0d",
                                 $time, exp_res.given, m_axis_tdata[5:0]);
                        mismatch_count++;
                    end
                    if (m_axis_tdata[69:6] !== exp_res.busy)
                    begin
                        $display("%0t: busy_map expected %h actual %h",
                                 $time, exp_res.busy, m_axis_tdata[69:6]);
                        mismatch_count++;
                    end
                end
            end

            if (rx_left == 0)
            begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(20, 200);
            end
            rx_left--;
            rx_phase++;
            case (rx_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= 1'($urandom_range(0, 1));
                2: m_axis_tready <= (rx_phase % 5 == 0);
                default: m_axis_tready <= (rx_phase % 16 >= 10);
            endcase

            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n          <= 1'b0;
        s_axis_tvalid  <= 1'b0;
        s_axis_tdata   <= '0;
        s_axis_tuser   <= 1'b0;
        m_axis_tready  <= 1'b0;
        alloc_busy     = '0;
        alloc_start    = '0;
        mismatch_count = 0;
        burst_left     = 0;
        idle_cycles    = 0;
        rx_mode        = 0;
        rx_left        = 0;
        rx_phase       = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_basics();
        test_exhaustion();
        test_random_traffic();

        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
